// ----- rtl/sha_pkg.sv -----
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions for the SHA-256 digest block.
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [31:0] data;
        logic        last;
    } t_word;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage

// ----- rtl/sha256_message_digest_top.sv -----
// ----------------------------------------------------------------------------
// sha256_message_digest_top
// SHA-256 digest of a byte stream, one byte per input transaction.
//
// Input channel: i_valid/o_stall with i_func and i_data_byte. func 0 appends
// a byte, func 1 finishes the message. Output channel: o_valid/i_stall with
// o_digest_word, o_word_index and o_last_word; eight transactions per
// finish, H0 first, o_last_word on H7.
// Bytes are packed into words and pass a four-word queue to the core. The
// core loads 16 words, runs one round per cycle and adds the hash. The
// queue lets the front run only four words ahead of the rounds, so with
// bytes back to back the front fills the queue and then stalls while the
// rounds and the add run; the rest of the block's bytes follow at one per cycle.
// A finish pushes the remaining pad words one per cycle while the queue is
// not full. The eight digest words follow one per cycle when unstalled.
// A stall on the output holds the result and the core, while the front keeps
// taking bytes until the queue is full. Reset (synchronous, active low)
// restores the initial hash and empties the queue; after each digest the
// hash returns to the initial values.
// ----------------------------------------------------------------------------
module sha256_message_digest_top #(
    parameter int unsigned QueueDepth = sha_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_func,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    import sha_pkg::*;

    t_word w_push_word;
    t_word w_pop_word;
    logic  w_push;
    logic  w_pop;
    logic  w_full;
    logic  w_empty;

    sha_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_func      (i_func),
        .i_data_byte (i_data_byte),
        .o_stall     (o_stall),
        .o_push      (w_push),
        .o_word      (w_push_word),
        .i_full      (w_full)
    );

    sha_fifo #(
        .Depth (QueueDepth)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_word),
        .i_pop   (w_pop),
        .o_data  (w_pop_word),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    sha_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_word        (w_pop_word),
        .i_empty       (w_empty),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

endmodule

// ----- rtl/sha_fifo.sv -----
// ----------------------------------------------------------------------------
// sha_fifo
// Short word queue between the packing front end and the compression core.
// ----------------------------------------------------------------------------
module sha_fifo #(
    parameter int unsigned Depth = sha_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sha_pkg::t_word i_data,
    input  logic           i_pop,
    output sha_pkg::t_word o_data,
    output logic           o_empty,
    output logic           o_full
);
    import sha_pkg::*;

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);

    t_word              r_mem [Depth];
    logic [PtrW-1:0]    r_wp;
    logic [PtrW-1:0]    r_rp;
    logic [CntW-1:0]    r_cnt;
    logic               w_push;
    logic               w_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CntW'(Depth));
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_push & ~o_full;
    assign w_pop   = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PtrW'(Depth - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == PtrW'(Depth - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ----- rtl/sha_front.sv -----
// ----------------------------------------------------------------------------
// sha_front
// Packs message bytes into words, counts the length and generates padding.
// ----------------------------------------------------------------------------
module sha_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_func,
    input  logic [7:0]     i_data_byte,
    output logic           o_stall,
    output logic           o_push,
    output sha_pkg::t_word o_word,
    input  logic           i_full
);
    import sha_pkg::*;

    logic [23:0] r_acc;
    logic [5:0]  r_fill;
    logic [63:0] r_bits;
    logic        r_pad;
    logic        r_two;
    logic [3:0]  r_widx;
    logic        w_accept;
    logic [31:0] w_padword;

    assign o_stall  = r_pad | i_full;
    assign w_accept = i_valid & ~o_stall;

    always_comb begin
        unique case (r_fill[1:0])
            2'd0:    w_padword = 32'h8000_0000;
            2'd1:    w_padword = {r_acc[7:0], 24'h80_0000};
            2'd2:    w_padword = {r_acc[15:0], 16'h8000};
            default: w_padword = {r_acc[23:0], 8'h80};
        endcase
    end

    always_comb begin
        o_push = 1'b0;
        o_word = '0;
        if (r_pad) begin
            o_push = ~i_full;
            if (r_widx == 4'd14 && !r_two) begin
                o_word.data = r_bits[63:32];
            end else if (r_widx == 4'd15 && !r_two) begin
                o_word.data = r_bits[31:0];
                o_word.last = 1'b1;
            end
        end else if (w_accept && i_func) begin
            o_push      = 1'b1;
            o_word.data = w_padword;
        end else if (w_accept) begin
            o_push      = (r_fill[1:0] == 2'd3);
            o_word.data = {r_acc, i_data_byte};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_bits <= '0;
            r_pad  <= 1'b0;
            r_two  <= 1'b0;
            r_widx <= '0;
        end else if (r_pad) begin
            if (o_push) begin
                r_widx <= r_widx + 1'b1;
                if (r_widx == 4'd15) begin
                    r_two <= 1'b0;
                end
                if (o_word.last) begin
                    r_pad  <= 1'b0;
                    r_fill <= '0;
                    r_bits <= '0;
                end
            end
        end else if (w_accept && i_func) begin
            r_pad  <= 1'b1;
            r_widx <= r_fill[5:2] + 1'b1;
            r_two  <= (r_fill[5:2] == 4'd14);
        end else if (w_accept) begin
            r_fill <= r_fill + 1'b1;
            r_bits <= r_bits + 64'd8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && !i_func) begin
            r_acc <= {r_acc[15:0], i_data_byte};
        end
    end

endmodule

// ----- rtl/sha_back.sv -----
// ----------------------------------------------------------------------------
// sha_back
// Loads 16 words, runs 64 compression rounds, adds into the hash and emits the digest words.
// ----------------------------------------------------------------------------
module sha_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sha_pkg::t_word i_word,
    input  logic           i_empty,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [31:0]    o_digest_word,
    output logic [2:0]     o_word_index,
    output logic           o_last_word
);
    import sha_pkg::*;

    typedef enum logic [3:0] {
        ST_LOAD  = 4'b0001,
        ST_ROUND = 4'b0010,
        ST_ADD   = 4'b0100,
        ST_OUT   = 4'b1000
    } t_state;

    t_state      r_state;
    logic [3:0]  r_cnt;
    logic [5:0]  r_round;
    logic        r_final;
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];
    logic [2:0]  r_oidx;
    logic        r_ovalid;
    logic [31:0] r_oword;
    logic [2:0]  r_oindex;
    logic        w_load_out;
    logic [31:0] w_new;
    logic [31:0] w_sched;
    logic [31:0] w_t1;
    logic [31:0] w_t2;

    assign o_pop         = (r_state == ST_LOAD) & ~i_empty;
    assign w_load_out    = (r_state == ST_OUT) & (~r_ovalid | ~i_stall);
    assign o_valid       = r_ovalid;
    assign o_digest_word = r_oword;
    assign o_word_index  = r_oindex;
    assign o_last_word   = (r_oindex == 3'd7);

    assign w_new   = small_sigma1(r_w[14]) + r_w[9] + small_sigma0(r_w[1]) + r_w[0];
    assign w_sched = (r_round < 6'd16) ? r_w[0] : w_new;
    assign w_t1    = r_v[7] + big_sigma1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
                   + K[r_round] + w_sched;
    assign w_t2    = big_sigma0(r_v[0])
                   + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_cnt    <= '0;
            r_round  <= '0;
            r_final  <= 1'b0;
            r_oidx   <= '0;
            r_ovalid <= 1'b0;
            r_h      <= IV;
        end else begin
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_LOAD: begin
                    if (o_pop) begin
                        r_final <= i_word.last;
                        r_cnt   <= r_cnt + 1'b1;
                        if (r_cnt == 4'd15) begin
                            r_state <= ST_ROUND;
                            r_round <= '0;
                        end
                    end
                end
                ST_ROUND: begin
                    r_round <= r_round + 1'b1;
                    if (r_round == 6'd63) begin
                        r_state <= ST_ADD;
                    end
                end
                ST_ADD: begin
                    for (int j = 0; j < 8; j++) begin
                        r_h[j] <= r_h[j] + r_v[j];
                    end
                    r_oidx  <= '0;
                    r_state <= r_final ? ST_OUT : ST_LOAD;
                end
                ST_OUT: begin
                    if (w_load_out) begin
                        r_ovalid <= 1'b1;
                        r_oidx   <= r_oidx + 1'b1;
                        if (r_oidx == 3'd7) begin
                            r_h     <= IV;
                            r_state <= ST_LOAD;
                        end
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            for (int j = 0; j < 15; j++) begin
                r_w[j] <= r_w[j+1];
            end
            r_w[15] <= i_word.data;
            if (r_cnt == 4'd15) begin
                r_v <= r_h;
            end
        end
        if (r_state == ST_ROUND) begin
            for (int j = 0; j < 15; j++) begin
                r_w[j] <= r_w[j+1];
            end
            r_w[15] <= w_sched;
            r_v[7]  <= r_v[6];
            r_v[6]  <= r_v[5];
            r_v[5]  <= r_v[4];
            r_v[4]  <= r_v[3] + w_t1;
            r_v[3]  <= r_v[2];
            r_v[2]  <= r_v[1];
            r_v[1]  <= r_v[0];
            r_v[0]  <= w_t1 + w_t2;
        end
        if (w_load_out) begin
            r_oword  <= r_h[r_oidx];
            r_oindex <= r_oidx;
        end
    end

    a_pop_only_in_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == ST_LOAD))
        else $error("queue popped outside load");

    a_add_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADD) |=> (r_state == ST_OUT || r_state == ST_LOAD))
        else $error("bad state after hash add");

    a_iv_restore: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load_out && r_oidx == 3'd7) |=> (r_h[0] == IV[0] && r_h[7] == IV[7]))
        else $error("hash not restored after digest");

endmodule

// ----- tb/sha256_digest_checker.sv -----
// ----------------------------------------------------------------------------
// sha256_digest_checker
// Watches both channels of the SHA-256 digest block, predicts each digest
// from the accepted byte and finish transactions, and compares every output
// transaction field by field against the oldest predicted word.
// ----------------------------------------------------------------------------
module sha256_digest_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_in_stall,
    input  logic        i_func,
    input  logic [7:0]  i_data_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [31:0] i_digest_word,
    input  logic [2:0]  i_word_index,
    input  logic        i_last_word,
    output int          o_errors,
    output int          o_pending,
    output int          o_digests
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_word;

    logic [31:0] hash_state [8];
    logic [7:0]  block_bytes [64];
    logic [5:0]  fill_count;
    logic [63:0] bit_length;
    t_digest_word expected_words [$];
    int          error_count;
    int          digest_count;
    int          pending_count;

    assign o_errors  = error_count;
    assign o_pending = pending_count;
    assign o_digests = digest_count;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2;
        for (int i = 0; i < 16; i++) begin
            w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2],
                    block_bytes[4*i+3]};
        end
        for (int i = 16; i < 64; i++) begin
            w[i] = (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                 + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
        end
        for (int j = 0; j < 8; j++) v[j] = hash_state[j];
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::K[i] + w[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int j = 0; j < 8; j++) hash_state[j] = hash_state[j] + v[j];
    endtask

    task automatic finish_message();
        int pos;
        pos = fill_count;
        block_bytes[pos] = 8'h80;
        pos++;
        if (pos > 56) begin
            while (pos < 64) begin
                block_bytes[pos] = 8'h00;
                pos++;
            end
            compress_block();
            pos = 0;
        end
        while (pos < 56) begin
            block_bytes[pos] = 8'h00;
            pos++;
        end
        for (int i = 0; i < 8; i++) block_bytes[56+i] = bit_length[63-8*i -: 8];
        compress_block();
        for (int i = 0; i < 8; i++) begin
            expected_words.push_back('{hash_state[i], 3'(i), i == 7});
        end
        for (int i = 0; i < 8; i++) hash_state[i] = sha_pkg::IV[i];
        fill_count = '0;
        bit_length = '0;
        digest_count++;
    endtask

    always @(posedge i_clk) begin
        t_digest_word got, exp_word;
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) hash_state[i] = sha_pkg::IV[i];
            fill_count = '0;
            bit_length = '0;
            expected_words.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = '{i_digest_word, i_word_index, i_last_word};
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word: expected none, actual %h idx %0d last %0b",
                             $time, got.word, got.index, got.last);
                    error_count++;
                end else begin
                    exp_word = expected_words.pop_front();
                    if (got !== exp_word) begin
                        $display("%0t: digest mismatch: expected %h idx %0d last %0b, actual %h idx %0d last %0b",
                                 $time, exp_word.word, exp_word.index, exp_word.last,
                                 got.word, got.index, got.last);
                        error_count++;
                    end
                end
            end
            if (i_valid && !i_in_stall) begin
                if (!i_func) begin
                    block_bytes[fill_count] = i_data_byte;
                    fill_count = fill_count + 6'd1;
                    bit_length = bit_length + 64'd8;
                    if (fill_count == 0) compress_block();
                end else begin
                    finish_message();
                end
            end
        end
        pending_count = expected_words.size();
    end

    initial begin
        error_count   = 0;
        digest_count  = 0;
        pending_count = 0;
        fill_count    = '0;
        bit_length    = '0;
    end
endmodule

// ----- tb/tb_sha256_message_digest_top.sv -----
// ----------------------------------------------------------------------------
// tb_sha256_message_digest_top
// Drives byte and finish transactions into the SHA-256 digest block with
// random gaps and output stalls: directed messages around the padding edges,
// then random messages of mostly short length; a checker predicts digests.
// ----------------------------------------------------------------------------
module tb_sha256_message_digest_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        in_func;
    logic [7:0]  in_byte;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    int          errors;
    int          pending;
    int          digests;
    int          sent_items;
    int          cycles;
    bit          no_gaps;

    sha256_message_digest_top DUT (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_func(in_func), .i_data_byte(in_byte), .o_valid(out_valid),
        .i_stall(out_stall), .o_digest_word(digest_word),
        .o_word_index(word_index), .o_last_word(last_word)
    );

    sha256_digest_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_in_stall(in_stall),
        .i_func(in_func), .i_data_byte(in_byte), .i_out_valid(out_valid),
        .i_out_stall(out_stall), .i_digest_word(digest_word),
        .i_word_index(word_index), .i_last_word(last_word),
        .o_errors(errors), .o_pending(pending), .o_digests(digests)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int gap_length();
        if (no_gaps) return 0;
        if ($urandom_range(9) < 6) return 0;
        if ($urandom_range(9) < 8) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    task automatic send_item(input logic func, input logic [7:0] data);
        int gap;
        gap = gap_length();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_func  <= func;
        in_byte  <= data;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent_items++;
    endtask

    task automatic send_message(input int len, input int pattern);
        for (int i = 0; i < len; i++) begin
            case (pattern)
                0: send_item(1'b0, 8'h00);
                1: send_item(1'b0, 8'hff);
                default: send_item(1'b0, 8'($urandom_range(255)));
            endcase
        end
        send_item(1'b1, 8'($urandom_range(255)));
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (no_gaps) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(9) < 3) ? 1'b1 :
                         ($urandom_range(99) == 0) ? 1'b1 : 1'b0;
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_sha256_message_digest_top: FAIL");
            $finish;
        end
    end

    initial begin
        int len;
        cycles     = 0;
        sent_items = 0;
        no_gaps    = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_func    = 1'b0;
        in_byte    = 8'h00;
        out_stall  = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_item(1'b1, 8'h00);
        send_message(3, 2);
        send_message(55, 0);
        send_message(56, 1);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        send_message(64, 2);
        no_gaps = 1'b1;
        send_message(63, 1);
        no_gaps = 1'b0;
        while (sent_items < 410) begin
            case ($urandom_range(9))
                0: len = $urandom_range(130, 50);
                1: len = 0;
                default: len = $urandom_range(12);
            endcase
            if ($urandom_range(5) == 0) no_gaps = 1'b1;
            send_message(len, $urandom_range(6) == 0 ? $urandom_range(1) : 2);
            no_gaps = 1'b0;
        end
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        $display("Run covered %0d input transactions and %0d digests,", sent_items, digests);
        $display("including empty, padding-edge, multi-block and all-ones messages.");
        if (errors == 0) begin
            $display("tb_sha256_message_digest_top: PASS");
        end else begin
            $display("tb_sha256_message_digest_top: FAIL");
        end
        $finish;
    end
endmodule
